### design/pev_pkg.sv
package pev_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_SLASH = 8'd47;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_DIVZ  = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_beat_t;

	typedef struct packed {
		logic signed [7:0] value;
		status_t           status;
	} out_beat_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t        op;
		logic [7:0] val;
		logic       last;
	} item_t;

endpackage

### design/postfix_expression_evaluator.sv
// Postfix evaluator on a 128-entry stack of signed 8-bit values. Beats carry one
// character and a last flag; a two-beat queue decouples intake from execution.
// A digit push is done in the idle state; + - * add an operand read state (the
// left operand comes from the stack RAM with a registered read; the right one is
// the cached top), and / also a radix-2 divider, one quotient bit per cycle. A
// beat with last set then loads the result register, which waits while res is
// stalled. No clearing pass is needed after reset. Status: 0 ok, 1 underflow,
// 2 divide by zero, 3 a push was dropped on a full stack. After an underflow or
// a divide by zero the rest of the expression is ignored and value reads 0.
module postfix_expression_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sym_valid,
	output logic               sym_stall,
	input  pev_pkg::in_beat_t  sym,
	output logic               res_valid,
	input  logic               res_stall,
	output pev_pkg::out_beat_t res
);
	import pev_pkg::*;

	logic  q_valid;
	logic  q_take;
	item_t q_item;

	pev_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sym_valid(sym_valid),
		.sym_stall(sym_stall),
		.sym      (sym),
		.q_valid  (q_valid),
		.q_take   (q_take),
		.q_item   (q_item)
	);

	pev_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_take   (q_take),
		.q_item   (q_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid)
		else $error("queue popped while empty");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> !sym_stall)
		else $error("input stalled with empty queue");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_UNDER || res.status == ST_DIVZ)
			|-> res.value == 8'sd0)
		else $error("error result carries nonzero value");

endmodule

### design/pev_front.sv
module pev_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sym_valid,
	output logic               sym_stall,
	input  pev_pkg::in_beat_t  sym,
	output logic               q_valid,
	input  logic               q_take,
	output pev_pkg::item_t     q_item
);
	import pev_pkg::*;

	item_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_CW-1:0]  cnt_q;
	item_t                cls;
	logic                 push;
	logic                 pop;

	always_comb begin
		cls.last = sym.last;
		cls.val  = sym.ch - CH_ZERO;
		case (sym.ch)
			CH_PLUS:  cls.op = OP_ADD;
			CH_MINUS: cls.op = OP_SUB;
			CH_STAR:  cls.op = OP_MUL;
			CH_SLASH: cls.op = OP_DIV;
			default:  cls.op = OP_PUSH;
		endcase
	end

	assign sym_stall = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
	assign push      = sym_valid && !sym_stall;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_take && q_valid;
	assign q_item    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QUEUE_CW'(1);
				2'b01:   cnt_q <= cnt_q - QUEUE_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### design/pev_div.sv
module pev_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic signed [7:0] num,
	input  logic signed [7:0] den,
	output logic              done,
	output logic        [7:0] quo
);
	import pev_pkg::*;

	logic [7:0] rem_q;
	logic [7:0] dvd_q;
	logic [7:0] den_q;
	logic       neg_q;
	logic [2:0] cnt_q;
	logic       busy_q;
	logic       done_q;
	logic [8:0] trial;
	logic       fits;

	// one restoring step per cycle on magnitudes; sign applied at the end
	assign trial = {rem_q, dvd_q[7]};
	assign fits  = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quo   = neg_q ? (8'd0 - dvd_q) : dvd_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= num[7] ? (8'd0 - num) : num;
			den_q <= den[7] ? (8'd0 - den) : den;
			neg_q <= num[7] ^ den[7];
		end else if (busy_q) begin
			rem_q <= fits ? 8'(trial - {1'b0, den_q}) : trial[7:0];
			dvd_q <= {dvd_q[6:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### design/pev_back.sv
module pev_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_take,
	input  pev_pkg::item_t     q_item,
	output logic               res_valid,
	input  logic               res_stall,
	output pev_pkg::out_beat_t res
);
	import pev_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_OPRD,
		S_DIV,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic [STACK_CW-1:0]  count_q;
	status_t              err_q;
	logic [7:0]           top_q;
	op_t                  cur_op_q;
	logic                 cur_last_q;
	logic                 res_valid_q;
	out_beat_t            res_q;

	// stack holds everything below the cached top
	logic [7:0]           stack_mem [STACK_DEPTH];
	logic [7:0]           rd_q;
	logic                 rd_en;
	logic                 wr_en;
	logic [STACK_AW-1:0]  rd_addr;
	logic [STACK_AW-1:0]  wr_addr;

	logic                 sticky;
	logic                 full;
	logic                 emit;
	logic                 div_start;
	logic                 div_done;
	logic [7:0]           div_quo;
	logic [7:0]           sum;
	logic [7:0]           diff;
	logic signed [15:0]   prod;
	state_t               after_op;

	assign sticky   = (err_q == ST_UNDER) || (err_q == ST_DIVZ);
	assign full     = (count_q == STACK_CW'(STACK_DEPTH));
	assign emit     = (state_q == S_EMIT) && (!res_valid_q || !res_stall);
	assign sum      = rd_q + top_q;
	assign diff     = rd_q - top_q;
	assign prod     = $signed(rd_q) * $signed(top_q);
	assign after_op = cur_last_q ? S_EMIT : S_IDLE;
	assign rd_addr  = STACK_AW'(count_q - STACK_CW'(2));
	assign wr_addr  = STACK_AW'(count_q - STACK_CW'(1));

	always_comb begin
		q_take    = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_take = 1'b1;
					if (!sticky) begin
						if (q_item.op == OP_PUSH) begin
							wr_en = (count_q != '0) && !full;
						end else begin
							rd_en = (count_q >= STACK_CW'(2));
						end
					end
				end
			end
			S_OPRD: begin
				div_start = (cur_op_q == OP_DIV) && (top_q != 8'd0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= top_q;
		end
		if (rd_en) begin
			rd_q <= stack_mem[rd_addr];
		end
	end

	pev_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (rd_q),
		.den   (top_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			err_q       <= ST_OK;
			top_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			cur_op_q    <= OP_PUSH;
			cur_last_q  <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_op_q   <= q_item.op;
						cur_last_q <= q_item.last;
						if (sticky) begin
							if (q_item.last) begin
								state_q <= S_EMIT;
							end
						end else if (q_item.op == OP_PUSH) begin
							if (full) begin
								if (err_q == ST_OK) begin
									err_q <= ST_FULL;
								end
							end else begin
								top_q   <= q_item.val;
								count_q <= count_q + STACK_CW'(1);
							end
							if (q_item.last) begin
								state_q <= S_EMIT;
							end
						end else if (count_q < STACK_CW'(2)) begin
							count_q <= '0;
							err_q   <= ST_UNDER;
							if (q_item.last) begin
								state_q <= S_EMIT;
							end
						end else begin
							state_q <= S_OPRD;
						end
					end
				end
				S_OPRD: begin
					case (cur_op_q)
						OP_ADD: begin
							top_q   <= sum;
							count_q <= count_q - STACK_CW'(1);
							state_q <= after_op;
						end
						OP_SUB: begin
							top_q   <= diff;
							count_q <= count_q - STACK_CW'(1);
							state_q <= after_op;
						end
						OP_MUL: begin
							top_q   <= prod[7:0];
							count_q <= count_q - STACK_CW'(1);
							state_q <= after_op;
						end
						default: begin
							if (top_q == 8'd0) begin
								err_q   <= ST_DIVZ;
								state_q <= after_op;
							end else begin
								state_q <= S_DIV;
							end
						end
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						top_q   <= div_quo;
						count_q <= count_q - STACK_CW'(1);
						state_q <= after_op;
					end
				end
				S_EMIT: begin
					if (emit) begin
						if (sticky) begin
							res_q.value  <= 8'sd0;
							res_q.status <= err_q;
						end else if (count_q == '0) begin
							res_q.value  <= 8'sd0;
							res_q.status <= ST_UNDER;
						end else begin
							res_q.value  <= $signed(top_q);
							res_q.status <= err_q;
						end
						count_q <= '0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### sim/postfix_expression_evaluator_tb.sv
module postfix_expression_evaluator_tb;
	import pev_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		in_beat_t    beat;
		int unsigned gap;
	} sym_slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sym_valid = 1'b0;
	logic sym_stall;
	in_beat_t sym_beat = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_beat_t res_beat;

	sym_slot_t sym_backlog[$];
	out_beat_t expected_res[$];
	int mismatches = 0;

	// predictor state
	logic signed [7:0] calc_stack [STACK_DEPTH];
	int calc_depth = 0;
	status_t calc_err = ST_OK;

	logic sym_fire = 1'b0;
	logic res_fire = 1'b0;
	int gap_left = 0;
	int stall_left = 2;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	postfix_expression_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym       (sym_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res_beat)
	);

	always #2 clk = ~clk;

	function automatic bit is_operator(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
	endfunction

	task automatic push_value(input logic signed [7:0] v);
		if (calc_depth >= STACK_DEPTH) begin
			if (calc_err == ST_OK)
				calc_err = ST_FULL;
		end else begin
			calc_stack[calc_depth] = v;
			calc_depth++;
		end
	endtask

	task automatic eval_symbol(input in_beat_t b);
		int lhs;
		int rhs;
		int r;
		out_beat_t o;
		if (calc_err != ST_UNDER && calc_err != ST_DIVZ) begin
			if (!is_operator(b.ch)) begin
				push_value(b.ch - CH_ZERO);
			end else if (calc_depth < 2) begin
				calc_depth = 0;
				calc_err = ST_UNDER;
			end else begin
				rhs = calc_stack[calc_depth - 1];
				lhs = calc_stack[calc_depth - 2];
				calc_depth -= 2;
				case (b.ch)
					CH_PLUS:  r = lhs + rhs;
					CH_MINUS: r = lhs - rhs;
					CH_STAR:  r = lhs * rhs;
					default:  r = (rhs == 0) ? 0 : lhs / rhs;
				endcase
				if (b.ch == CH_SLASH && rhs == 0)
					calc_err = ST_DIVZ;
				else
					push_value(r[7:0]);
			end
		end
		if (b.last) begin
			o.value = '0;
			if (calc_err == ST_UNDER || calc_err == ST_DIVZ) begin
				o.status = calc_err;
			end else if (calc_depth == 0) begin
				o.status = ST_UNDER;
			end else begin
				o.value = calc_stack[calc_depth - 1];
				o.status = calc_err;
			end
			expected_res.push_back(o);
			calc_depth = 0;
			calc_err = ST_OK;
		end
	endtask

	task automatic put_sym(input logic [7:0] c, input logic l);
		sym_slot_t s;
		s.beat.ch = c;
		s.beat.last = l;
		s.gap = tx_quiet ? 0 : $urandom_range(0, 4);
		sym_backlog.push_back(s);
	endtask

	function automatic logic [7:0] rand_operand();
		logic [7:0] c;
		if ($urandom_range(0, 99) < 85)
			return 8'(CH_ZERO + $urandom_range(0, 9));
		c = 8'($urandom_range(0, 255));
		while (is_operator(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic logic [7:0] rand_operator();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// kind: 0 well formed, 1 broken, 2 noise, 3 overfills the stack
	task automatic gen_expression(input int kind);
		logic [7:0] chars[$];
		int n_opnd;
		int pushed;
		int lvl;
		int pos;
		n_opnd = (kind == 3) ? STACK_DEPTH + $urandom_range(1, 4) : $urandom_range(1, 6);
		pushed = 0;
		lvl = 0;
		if (kind == 2) begin
			repeat ($urandom_range(1, 8))
				chars.push_back(($urandom_range(0, 9) < 3) ? rand_operator()
						: 8'($urandom_range(0, 255)));
		end else begin
			while (pushed < n_opnd || lvl > 1) begin
				if (pushed < n_opnd && (lvl < 2 || kind == 3 || $urandom_range(0, 1))) begin
					chars.push_back(rand_operand());
					pushed++;
					lvl++;
				end else begin
					chars.push_back(rand_operator());
					lvl--;
					if (kind == 3 && $urandom_range(0, 1))
						break;
				end
			end
		end
		if (kind == 1) begin
			pos = $urandom_range(0, chars.size());
			if ($urandom_range(0, 1) || chars.size() < 2)
				chars.insert(pos, rand_operator());
			else
				chars.delete(pos % chars.size());
		end
		foreach (chars[i])
			put_sym(chars[i], i == chars.size() - 1);
	endtask

	// driver: next beat goes out once the previous one was taken
	always @(negedge clk) begin : drv
		sym_slot_t slot;
		if (arst_n && (!sym_valid || sym_fire)) begin
			if (gap_left > 0) begin
				sym_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (sym_backlog.size() > 0) begin
				slot = sym_backlog.pop_front();
				sym_beat <= slot.beat;
				sym_valid <= 1'b1;
				gap_left <= slot.gap;
			end else begin
				sym_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure, redrawn after every accepted beat
	always @(negedge clk) begin : rx
		int n;
		if (res_fire) begin
			n = rx_quiet ? 0 : $urandom_range(0, 4);
			if ($urandom_range(0, 15) == 0)
				rx_quiet <= ~rx_quiet;
			res_stall <= (n != 0);
			stall_left <= (n == 0) ? 0 : n - 1;
		end else if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : mon
		out_beat_t want;
		sym_fire <= sym_valid && !sym_stall;
		res_fire <= res_valid && !res_stall;
		if (arst_n) begin
			if (sym_valid && !sym_stall)
				eval_symbol(sym_beat);
			if (res_valid && !res_stall) begin
				if (expected_res.size() == 0) begin
					mismatches++;
					$display("%0t: expected no result, got value %0d status %0d",
						$realtime, res_beat.value, res_beat.status);
				end else begin
					want = expected_res.pop_front();
					if (res_beat.value !== want.value || res_beat.status !== want.status) begin
						mismatches++;
						$display("%0t: expected value %0d status %0d, got value %0d status %0d",
							$realtime, want.value, want.status,
							res_beat.value, res_beat.status);
					end
				end
			end
		end
	end

	initial begin
		int n_rand;
		int pick;

		// directed
		put_sym(8'(CH_ZERO + 3), 1'b0);
		put_sym(8'(CH_ZERO + 4), 1'b0);
		put_sym(CH_PLUS, 1'b1);
		put_sym(8'(CH_ZERO + 9), 1'b0);
		put_sym(8'(CH_ZERO + 5), 1'b0);
		put_sym(CH_MINUS, 1'b1);
		put_sym(8'h00, 1'b0);
		put_sym(8'hFF, 1'b0);
		put_sym(CH_STAR, 1'b1);
		put_sym(8'(CH_ZERO - 7), 1'b0);
		put_sym(8'(CH_ZERO + 2), 1'b0);
		put_sym(CH_SLASH, 1'b1);
		// divide by zero, then a digit that must be ignored
		put_sym(8'(CH_ZERO + 5), 1'b0);
		put_sym(CH_ZERO, 1'b0);
		put_sym(CH_SLASH, 1'b0);
		put_sym(8'(CH_ZERO + 1), 1'b1);
		put_sym(CH_PLUS, 1'b1);
		// -128 / -1 wraps back to -128
		put_sym(8'd176, 1'b0);
		put_sym(CH_ZERO, 1'b0);
		put_sym(8'(CH_ZERO + 1), 1'b0);
		put_sym(CH_MINUS, 1'b0);
		put_sym(CH_SLASH, 1'b1);

		// random
		gen_expression(3);
		n_rand = sym_backlog.size();
		while (n_rand < 1050) begin
			if ($urandom_range(0, 7) == 0)
				tx_quiet = ~tx_quiet;
			pick = $urandom_range(0, 99);
			n_rand -= sym_backlog.size();
			if (pick < 70)
				gen_expression(0);
			else if (pick < 82)
				gen_expression(1);
			else if (pick < 99)
				gen_expression(2);
			else
				gen_expression(3);
			n_rand += sym_backlog.size();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (sym_backlog.size() > 0 || sym_valid || expected_res.size() > 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_res.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
design/pev_pkg.sv
design/pev_front.sv
design/pev_div.sv
design/pev_back.sv
design/postfix_expression_evaluator.sv
sim/postfix_expression_evaluator_tb.sv
